// ===== hdl/attitude_pid_quad_mixer_defines.svh =====
// assertion helpers shared by the attitude controller modules
`ifndef ATTITUDE_PID_QUAD_MIXER_DEFINES_SVH
`define ATTITUDE_PID_QUAD_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ATTPID_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ATTPID_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/attpid_pkg.sv =====
`timescale 1ns / 1ps

package attpid_pkg;

   // field widths
   localparam int ANGLE_W  = 15;
   localparam int ERR_W    = 16;
   localparam int THR_W    = 13;
   localparam int CMD_W    = 13;
   localparam int GAIN_W   = 16;
   localparam int ILIM_W   = 20;
   localparam int LIMIT_W  = 12;
   localparam int INTEG_W  = 32;
   localparam int KD_W     = 32;
   localparam int KD_YAW_W = 30;
   localparam int SUM_W    = 52;
   localparam int MIX_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // fixed-point scaling
   localparam int P_SHIFT   = 16;
   localparam int OUT_SHIFT = 30;
   localparam int YAW_KD_NUM = 13107;

   // half and full turn in 1/64 degree
   localparam logic signed [ERR_W:0] DEG180 = (ERR_W + 1)'(180 * 64);
   localparam logic signed [ERR_W:0] DEG360 = (ERR_W + 1)'(360 * 64);

   // parameter defaults
   localparam int THROTTLE_LIMIT_DEF = 4095;
   localparam int MOTOR_WIDTH_DEF    = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_CMD_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_CMD_LIMIT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_LIMIT   = 3'd7;

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd3840;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd0;
   localparam logic [GAIN_W-1:0]  INTEG_STEP_RST  = 16'd655;
   localparam logic [ILIM_W-1:0]  INTEG_LIMIT_RST = 20'd65536;
   localparam logic [LIMIT_W-1:0] YAW_LIMIT_RST   = 12'd200;
   localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST  = 12'd400;
   localparam logic [LIMIT_W-1:0] MOTOR_LIMIT_RST = 12'd4095;

   // pipeline depth: five lane stages and the mixer output stage
   localparam int NSTAGE = 6;
   localparam int ST_OUT = NSTAGE - 1;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic s0;
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic mix;
   } attpid_load_type;

endpackage

// ===== hdl/attpid_lane.sv =====
`timescale 1ns / 1ps
`include "attitude_pid_quad_mixer_defines.svh"

module attpid_lane import attpid_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  attpid_load_type            ld,
   input  logic signed [ANGLE_W-1:0]  want,
   input  logic signed [ANGLE_W-1:0]  meas,
   input  logic                       wrap_en,
   input  logic        [GAIN_W-1:0]   gain_p,
   input  logic        [GAIN_W-1:0]   gain_i,
   input  logic        [GAIN_W-1:0]   integ_step,
   input  logic        [KD_W-1:0]     kd,
   input  logic        [ILIM_W-1:0]   integ_limit,
   input  logic        [LIMIT_W-1:0]  cmd_limit,
   output logic signed [CMD_W-1:0]    cmd
);

   // stage 0: error, heading wrap, error difference
   logic signed [ERR_W:0]   diff_raw;
   logic signed [ERR_W:0]   diff_wrap;
   logic signed [ERR_W-1:0] err_in;
   logic signed [ERR_W:0]   de_in;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [ERR_W:0]   de_ff;
   logic signed [ERR_W-1:0] prev_ff;

   always_comb begin
      diff_raw = (ERR_W + 1)'(want) - (ERR_W + 1)'(meas);
      diff_wrap = diff_raw;
      if (wrap_en) begin
         if (diff_raw < -DEG180) begin
            diff_wrap = diff_raw + DEG360;
         end else if (diff_raw > DEG180) begin
            diff_wrap = diff_raw - DEG360;
         end
      end
      err_in = $signed(diff_wrap[ERR_W-1:0]);
      de_in  = (ERR_W + 1)'(err_in) - (ERR_W + 1)'(prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ld.s0) begin
         prev_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s0) begin
         err_ff <= err_in;
         de_ff  <= de_in;
      end
   end

   // stage 1: the three error products
   logic signed [ERR_W+GAIN_W:0]  p_int_in;
   logic signed [ERR_W+GAIN_W:0]  prod_p_in;
   logic signed [ERR_W+KD_W+1:0]  prod_d_in;
   logic signed [ERR_W+GAIN_W:0]  p_int_ff;
   logic signed [ERR_W+GAIN_W:0]  prod_p_s1_ff;
   logic signed [ERR_W+KD_W+1:0]  prod_d_s1_ff;

   assign p_int_in  = err_ff * $signed({1'b0, integ_step});
   assign prod_p_in = err_ff * $signed({1'b0, gain_p});
   assign prod_d_in = de_ff * $signed({1'b0, kd});

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         p_int_ff     <= p_int_in;
         prod_p_s1_ff <= prod_p_in;
         prod_d_s1_ff <= prod_d_in;
      end
   end

   // stage 2: integrator update, clamp or saturating accumulate
   logic signed [ILIM_W:0]    ilim_s;
   logic signed [INTEG_W+1:0] integ_acc;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W+GAIN_W:0]  prod_p_s2_ff;
   logic signed [ERR_W+KD_W+1:0]  prod_d_s2_ff;

   always_comb begin
      ilim_s    = $signed({1'b0, integ_limit});
      integ_acc = (INTEG_W + 2)'(integ_ff) + (INTEG_W + 2)'(p_int_ff);
      if (integ_ff > ilim_s) begin
         integ_in = INTEG_W'(ilim_s);
      end else if (integ_ff < -ilim_s) begin
         integ_in = INTEG_W'(-ilim_s);
      end else if (!integ_acc[INTEG_W+1]
                   && (integ_acc[INTEG_W] || integ_acc[INTEG_W-1])) begin
         integ_in = {1'b0, {(INTEG_W - 1){1'b1}}};
      end else if (integ_acc[INTEG_W+1]
                   && !(integ_acc[INTEG_W] && integ_acc[INTEG_W-1])) begin
         integ_in = {1'b1, {(INTEG_W - 1){1'b0}}};
      end else begin
         integ_in = $signed(integ_acc[INTEG_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (ld.s2) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s2) begin
         prod_p_s2_ff <= prod_p_s1_ff;
         prod_d_s2_ff <= prod_d_s1_ff;
      end
   end

   // stage 3: integral product, proportional plus derivative
   logic signed [INTEG_W+GAIN_W:0] prod_i_in;
   logic signed [SUM_W-1:0]        sum_pd_in;
   logic signed [INTEG_W+GAIN_W:0] prod_i_ff;
   logic signed [SUM_W-1:0]        sum_pd_ff;

   assign prod_i_in = integ_ff * $signed({1'b0, gain_i});
   assign sum_pd_in = (SUM_W'(prod_p_s2_ff) <<< P_SHIFT) + SUM_W'(prod_d_s2_ff);

   always_ff @(posedge clock) begin
      if (ld.s3) begin
         prod_i_ff <= prod_i_in;
         sum_pd_ff <= sum_pd_in;
      end
   end

   // stage 4: full sum, scale down, clamp to the axis limit
   logic signed [SUM_W-1:0]           sum_all;
   logic signed [SUM_W-OUT_SHIFT-1:0] scaled;
   logic signed [CMD_W-1:0]           lim_s;
   logic signed [CMD_W-1:0]           cmd_in;
   logic signed [CMD_W-1:0]           cmd_ff;

   always_comb begin
      sum_all = sum_pd_ff + SUM_W'(prod_i_ff);
      scaled  = $signed(sum_all[SUM_W-1:OUT_SHIFT]);
      lim_s   = $signed({1'b0, cmd_limit});
      if (scaled > lim_s) begin
         cmd_in = lim_s;
      end else if (scaled < -lim_s) begin
         cmd_in = -lim_s;
      end else begin
         cmd_in = $signed(scaled[CMD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s4) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

   `ATTPID_ASSERT_NEXT(a_cmd_in_limit, ld.s4,
      (cmd_ff <= $signed({1'b0, $past(cmd_limit)}))
      && (cmd_ff >= -$signed({1'b0, $past(cmd_limit)})),
      "axis command outside its limit")

endmodule

// ===== hdl/attpid_mixer.sv =====
`timescale 1ns / 1ps
`include "attitude_pid_quad_mixer_defines.svh"

module attpid_mixer import attpid_pkg::*; #(
   parameter int MOTOR_WIDTH = MOTOR_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  attpid_load_type            ld,
   input  logic signed [CMD_W-1:0]    pitch,
   input  logic signed [CMD_W-1:0]    roll,
   input  logic signed [CMD_W-1:0]    yaw,
   input  logic signed [THR_W-1:0]    thr,
   input  logic        [LIMIT_W-1:0]  motor_limit,
   output logic [MOTOR_WIDTH-1:0]     motor_front_left,
   output logic [MOTOR_WIDTH-1:0]     motor_front_right,
   output logic [MOTOR_WIDTH-1:0]     motor_rear_left,
   output logic [MOTOR_WIDTH-1:0]     motor_rear_right,
   output logic signed [CMD_W-1:0]    pitch_cmd,
   output logic signed [CMD_W-1:0]    roll_cmd,
   output logic signed [CMD_W-1:0]    yaw_cmd
);

   // largest value the motor port can carry
   localparam logic [LIMIT_W-1:0] WIDTH_MAX = (MOTOR_WIDTH >= LIMIT_W)
      ? {LIMIT_W{1'b1}} : LIMIT_W'((1 << MOTOR_WIDTH) - 1);

   function automatic logic [MIX_W-1:0] clamp_motor(
      input logic signed [MIX_W-1:0] v,
      input logic [LIMIT_W-1:0]      top
   );
      logic signed [MIX_W-1:0] top_s;
      logic [MIX_W-1:0]        res;
      top_s = $signed(MIX_W'(top));
      if (v < 0) begin
         res = '0;
      end else if (v > top_s) begin
         res = MIX_W'(top);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // x-frame mix
   logic [LIMIT_W-1:0]      motor_top;
   logic signed [MIX_W-1:0] mix_fl;
   logic signed [MIX_W-1:0] mix_fr;
   logic signed [MIX_W-1:0] mix_rl;
   logic signed [MIX_W-1:0] mix_rr;
   logic [MIX_W-1:0]        fl_in;
   logic [MIX_W-1:0]        fr_in;
   logic [MIX_W-1:0]        rl_in;
   logic [MIX_W-1:0]        rr_in;

   always_comb begin
      motor_top = (motor_limit < WIDTH_MAX) ? motor_limit : WIDTH_MAX;
      mix_fl = MIX_W'(thr) - MIX_W'(yaw) + MIX_W'(roll) + MIX_W'(pitch);
      mix_fr = MIX_W'(thr) + MIX_W'(yaw) - MIX_W'(roll) + MIX_W'(pitch);
      mix_rl = MIX_W'(thr) + MIX_W'(yaw) + MIX_W'(roll) - MIX_W'(pitch);
      mix_rr = MIX_W'(thr) - MIX_W'(yaw) - MIX_W'(roll) - MIX_W'(pitch);
      fl_in  = clamp_motor(mix_fl, motor_top);
      fr_in  = clamp_motor(mix_fr, motor_top);
      rl_in  = clamp_motor(mix_rl, motor_top);
      rr_in  = clamp_motor(mix_rr, motor_top);
   end

   // output register
   always_ff @(posedge clock) begin
      if (ld.mix) begin
         motor_front_left  <= MOTOR_WIDTH'(fl_in);
         motor_front_right <= MOTOR_WIDTH'(fr_in);
         motor_rear_left   <= MOTOR_WIDTH'(rl_in);
         motor_rear_right  <= MOTOR_WIDTH'(rr_in);
         pitch_cmd         <= pitch;
         roll_cmd          <= roll;
         yaw_cmd           <= yaw;
      end
   end

   `ATTPID_ASSERT_NEXT(a_motor_top, ld.mix,
      (motor_front_left <= $past(motor_top)) && (motor_front_right <= $past(motor_top))
      && (motor_rear_left <= $past(motor_top)) && (motor_rear_right <= $past(motor_top)),
      "motor value above its upper clamp")

endmodule

// ===== hdl/attitude_pid_quad_mixer.sv =====
`timescale 1ns / 1ps
`include "attitude_pid_quad_mixer_defines.svh"
// Three-axis attitude PID with an X-frame quad motor mixer.
// Input channel req_*: one control tick per transfer (desired and measured
// pitch, roll, yaw and throttle). Result channel rsp_*: four clamped motor
// drives and the three clamped axis commands, one result per tick.
// Configuration: csr_we, csr_index, csr_wdata write one gain or limit register;
// write only while no tick is in flight.
// Pitch, roll and yaw each run in their own lane; the mixer stage combines
// the three lane commands with the throttle.
// Pipeline: the first of the six registered stages (five lane stages plus the
// mixer output register) loads on the transfer edge itself; rsp_valid rises
// when the tick reaches the output register. Throughput: one tick per cycle
// while rsp_stall is low; the integrator feedback closes in one lane stage.
// Stalls: each stage moves when the stage after it is empty or moving, so a
// stalled result holds in the output register while up to five more ticks
// are taken in; req_stall rises only when all six stages are full.
// Reset: clears integrators, previous errors and all stage valids, and loads
// the register defaults.
module attitude_pid_quad_mixer import attpid_pkg::*; #(
   parameter int THROTTLE_LIMIT = THROTTLE_LIMIT_DEF,
   parameter int MOTOR_WIDTH    = MOTOR_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [ANGLE_W-1:0]  req_want_pitch,
   input  logic signed [ANGLE_W-1:0]  req_want_roll,
   input  logic signed [ANGLE_W-1:0]  req_want_yaw,
   input  logic signed [ANGLE_W-1:0]  req_meas_pitch,
   input  logic signed [ANGLE_W-1:0]  req_meas_roll,
   input  logic signed [ANGLE_W-1:0]  req_meas_yaw,
   input  logic signed [THR_W-1:0]    req_throttle_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [MOTOR_WIDTH-1:0]     rsp_motor_front_left,
   output logic [MOTOR_WIDTH-1:0]     rsp_motor_front_right,
   output logic [MOTOR_WIDTH-1:0]     rsp_motor_rear_left,
   output logic [MOTOR_WIDTH-1:0]     rsp_motor_rear_right,
   output logic signed [CMD_W-1:0]    rsp_pitch_cmd,
   output logic signed [CMD_W-1:0]    rsp_roll_cmd,
   output logic signed [CMD_W-1:0]    rsp_yaw_cmd,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic signed [THR_W-1:0] THR_MAX = THR_W'(THROTTLE_LIMIT);

   // configuration registers
   logic [GAIN_W-1:0]   gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0]   gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0]   gain_d_ff, gain_d_in;
   logic [KD_YAW_W-1:0] kd_yaw_ff, kd_yaw_in;
   logic [GAIN_W-1:0]   integ_step_ff, integ_step_in;
   logic [ILIM_W-1:0]   integ_limit_ff, integ_limit_in;
   logic [LIMIT_W-1:0]  yaw_limit_ff, yaw_limit_in;
   logic [LIMIT_W-1:0]  tilt_limit_ff, tilt_limit_in;
   logic [LIMIT_W-1:0]  motor_limit_ff, motor_limit_in;

   always_comb begin
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      kd_yaw_in      = kd_yaw_ff;
      integ_step_in  = integ_step_ff;
      integ_limit_in = integ_limit_ff;
      yaw_limit_in   = yaw_limit_ff;
      tilt_limit_in  = tilt_limit_ff;
      motor_limit_in = motor_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:         gain_p_in = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         gain_i_in = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D: begin
               gain_d_in = csr_wdata[GAIN_W-1:0];
               // yaw derivative gain is 0.2 of the shared one
               kd_yaw_in = KD_YAW_W'(csr_wdata[GAIN_W-1:0] * YAW_KD_NUM);
            end
            CSR_INTEG_STEP:     integ_step_in  = csr_wdata[GAIN_W-1:0];
            CSR_INTEG_LIMIT:    integ_limit_in = csr_wdata[ILIM_W-1:0];
            CSR_YAW_CMD_LIMIT:  yaw_limit_in   = csr_wdata[LIMIT_W-1:0];
            CSR_TILT_CMD_LIMIT: tilt_limit_in  = csr_wdata[LIMIT_W-1:0];
            CSR_MOTOR_LIMIT:    motor_limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= GAIN_P_RST;
         gain_i_ff      <= GAIN_I_RST;
         gain_d_ff      <= GAIN_D_RST;
         kd_yaw_ff      <= KD_YAW_W'(GAIN_D_RST * YAW_KD_NUM);
         integ_step_ff  <= INTEG_STEP_RST;
         integ_limit_ff <= INTEG_LIMIT_RST;
         yaw_limit_ff   <= YAW_LIMIT_RST;
         tilt_limit_ff  <= TILT_LIMIT_RST;
         motor_limit_ff <= MOTOR_LIMIT_RST;
      end else begin
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         kd_yaw_ff      <= kd_yaw_in;
         integ_step_ff  <= integ_step_in;
         integ_limit_ff <= integ_limit_in;
         yaw_limit_ff   <= yaw_limit_in;
         tilt_limit_ff  <= tilt_limit_in;
         motor_limit_ff <= motor_limit_in;
      end
   end

   // pipeline control: a stage moves when the next one is empty or moving
   logic [NSTAGE-1:0] stage_valid_ff, stage_valid_in;
   logic [NSTAGE-1:0] stage_en;
   logic [NSTAGE-1:0] stage_load;
   attpid_load_type   ld;

   always_comb begin
      stage_en[ST_OUT] = !stage_valid_ff[ST_OUT] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
      stage_load[0]     = stage_en[0] && req_valid;
      stage_valid_in[0] = stage_en[0] ? req_valid : stage_valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         stage_load[k]     = stage_en[k] && stage_valid_ff[k-1];
         stage_valid_in[k] = stage_en[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign ld.s0  = stage_load[0];
   assign ld.s1  = stage_load[1];
   assign ld.s2  = stage_load[2];
   assign ld.s3  = stage_load[3];
   assign ld.s4  = stage_load[4];
   assign ld.mix = stage_load[ST_OUT];

   assign req_stall = !stage_en[0];
   assign rsp_valid = stage_valid_ff[ST_OUT];

   // throttle clamp and carry alongside the lanes
   logic signed [THR_W-1:0] thr_in;
   logic signed [THR_W-1:0] thr_s0_ff, thr_s1_ff, thr_s2_ff, thr_s3_ff, thr_s4_ff;

   always_comb begin
      if (req_throttle_in > THR_MAX) begin
         thr_in = THR_MAX;
      end else if (req_throttle_in < -THR_MAX) begin
         thr_in = -THR_MAX;
      end else begin
         thr_in = req_throttle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s0) thr_s0_ff <= thr_in;
      if (ld.s1) thr_s1_ff <= thr_s0_ff;
      if (ld.s2) thr_s2_ff <= thr_s1_ff;
      if (ld.s3) thr_s3_ff <= thr_s2_ff;
      if (ld.s4) thr_s4_ff <= thr_s3_ff;
   end

   // one lane per axis
   logic [KD_W-1:0]         kd_tilt;
   logic [KD_W-1:0]         kd_yaw;
   logic signed [CMD_W-1:0] pitch_lane_cmd;
   logic signed [CMD_W-1:0] roll_lane_cmd;
   logic signed [CMD_W-1:0] yaw_lane_cmd;

   assign kd_tilt = {gain_d_ff, {P_SHIFT{1'b0}}};
   assign kd_yaw  = KD_W'(kd_yaw_ff);

   attpid_lane u_lane_pitch (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld),
      .want        (req_want_pitch),
      .meas        (req_meas_pitch),
      .wrap_en     (1'b0),
      .gain_p      (gain_p_ff),
      .gain_i      (gain_i_ff),
      .integ_step  (integ_step_ff),
      .kd          (kd_tilt),
      .integ_limit (integ_limit_ff),
      .cmd_limit   (tilt_limit_ff),
      .cmd         (pitch_lane_cmd)
   );

   attpid_lane u_lane_roll (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld),
      .want        (req_want_roll),
      .meas        (req_meas_roll),
      .wrap_en     (1'b0),
      .gain_p      (gain_p_ff),
      .gain_i      (gain_i_ff),
      .integ_step  (integ_step_ff),
      .kd          (kd_tilt),
      .integ_limit (integ_limit_ff),
      .cmd_limit   (tilt_limit_ff),
      .cmd         (roll_lane_cmd)
   );

   attpid_lane u_lane_yaw (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld),
      .want        (req_want_yaw),
      .meas        (req_meas_yaw),
      .wrap_en     (1'b1),
      .gain_p      (gain_p_ff),
      .gain_i      (gain_i_ff),
      .integ_step  (integ_step_ff),
      .kd          (kd_yaw),
      .integ_limit (integ_limit_ff),
      .cmd_limit   (yaw_limit_ff),
      .cmd         (yaw_lane_cmd)
   );

   // mixer and output register
   attpid_mixer #(
      .MOTOR_WIDTH (MOTOR_WIDTH)
   ) u_mixer (
      .clock             (clock),
      .reset             (reset),
      .ld                (ld),
      .pitch             (pitch_lane_cmd),
      .roll              (roll_lane_cmd),
      .yaw               (yaw_lane_cmd),
      .thr               (thr_s4_ff),
      .motor_limit       (motor_limit_ff),
      .motor_front_left  (rsp_motor_front_left),
      .motor_front_right (rsp_motor_front_right),
      .motor_rear_left   (rsp_motor_rear_left),
      .motor_rear_right  (rsp_motor_rear_right),
      .pitch_cmd         (rsp_pitch_cmd),
      .roll_cmd          (rsp_roll_cmd),
      .yaw_cmd           (rsp_yaw_cmd)
   );

   `ATTPID_ASSERT_NOW(a_stall_only_when_full, req_stall, &stage_valid_ff,
      "input stalled with an empty stage in the pipeline")

   `ATTPID_ASSERT_NEXT(a_transfer_enters_s0, req_valid && !req_stall, stage_valid_ff[0],
      "accepted tick did not enter the first stage")

   `ATTPID_ASSERT_NEXT(a_blocked_s4_holds, stage_valid_ff[4] && !stage_en[4],
      stage_valid_ff[4], "blocked tick dropped from the last lane stage")

endmodule
